// ----- rtl/adcseq_pkg.sv -----
// Shared types, widths and constants of the converter scan sequencer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package adcseq_pkg;

   localparam int DEPTH      = 8;          // entries per channel ring, 1 to 64
   localparam int NUM_CHAN   = 4;
   localparam int SAMPLE_W   = 10;
   localparam int AVG_W      = 10;
   localparam int MUX_W      = 3;
   localparam int CH_W       = 2;
   localparam int DROP_W     = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int ENTRIES = NUM_CHAN * DEPTH;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int POS_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Ring sum never exceeds DEPTH * 1023, so it never wraps at SUM_W (13) bits.
   localparam int SUM_W     = $clog2(DEPTH * 1023 + 1);
   localparam int DIV_L     = $clog2(DEPTH);
   localparam int DIV_SHIFT = SUM_W + DIV_L;
   localparam int RECIP_W   = SUM_W + 2;
   localparam int PROD_W    = SUM_W + RECIP_W;
   // Rounded-up reciprocal: exact floor division for every sum below 2**SUM_W.
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((2 ** DIV_SHIFT) + DEPTH - 1) / DEPTH);

   typedef logic [CH_W-1:0] chan_type;
   localparam chan_type CH_LEFT    = 2'd0;
   localparam chan_type CH_MIDDLE  = 2'd1;
   localparam chan_type CH_RIGHT   = 2'd2;
   localparam chan_type CH_BATTERY = 2'd3;

   localparam logic FUNC_CONVERT = 1'b0;
   localparam logic FUNC_QUERY   = 1'b1;

   typedef enum logic [2:0] {
      REG_DROP_COUNT  = 3'd0,
      REG_MUX_LEFT    = 3'd1,
      REG_MUX_MIDDLE  = 3'd2,
      REG_MUX_RIGHT   = 3'd3,
      REG_MUX_BATTERY = 3'd4
   } reg_index_type;

   localparam logic [DROP_W-1:0] DROP_COUNT_RESET  = 4'd3;
   localparam logic [MUX_W-1:0]  MUX_LEFT_RESET    = 3'd0;
   localparam logic [MUX_W-1:0]  MUX_MIDDLE_RESET  = 3'd1;
   localparam logic [MUX_W-1:0]  MUX_RIGHT_RESET   = 3'd2;
   localparam logic [MUX_W-1:0]  MUX_BATTERY_RESET = 3'd3;

   typedef struct packed {
      logic [DROP_W-1:0]              drop_count;
      logic [NUM_CHAN-1:0][MUX_W-1:0] mux_code;
   } cfg_type;

   // One transaction between the scan stage and the accumulate stage.
   typedef struct packed {
      logic                func;
      logic                keep;
      chan_type            channel;
      chan_type            query_channel;
      logic [SAMPLE_W-1:0] sample;
      logic [MUX_W-1:0]    mux_select;
      logic [ADDR_W-1:0]   addr;
   } stage_type;

endpackage

// ----- rtl/adcseq_if.sv -----
// Valid/ready channel interfaces for the request and response transactions.
// Depends on adcseq_pkg.
`timescale 1ns / 1ps

interface adcseq_req_if import adcseq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                func;
   logic [SAMPLE_W-1:0] sample;
   logic [CH_W-1:0]     query_channel;

   modport source (output valid, func, sample, query_channel, input ready);
   modport sink   (input valid, func, sample, query_channel, output ready);
endinterface

interface adcseq_rsp_if import adcseq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                stored;
   logic [CH_W-1:0]     stored_channel;
   logic [MUX_W-1:0]    mux_select;
   logic [AVG_W-1:0]    average;

   modport source (output valid, stored, stored_channel, mux_select, average, input ready);
   modport sink   (input valid, stored, stored_channel, mux_select, average, output ready);
endinterface

// ----- rtl/adcseq_csr.sv -----
// APB-style configuration registers: drop count and the four mux codes.
// Depends on adcseq_pkg.
`timescale 1ns / 1ps

module adcseq_csr import adcseq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_DROP_COUNT:  cfg_in.drop_count  = csr_pwdata[DROP_W-1:0];
            REG_MUX_LEFT:    cfg_in.mux_code[0] = csr_pwdata[MUX_W-1:0];
            REG_MUX_MIDDLE:  cfg_in.mux_code[1] = csr_pwdata[MUX_W-1:0];
            REG_MUX_RIGHT:   cfg_in.mux_code[2] = csr_pwdata[MUX_W-1:0];
            REG_MUX_BATTERY: cfg_in.mux_code[3] = csr_pwdata[MUX_W-1:0];
            default:         cfg_in = cfg_ff;   // drop writes beyond the map
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (index)
         REG_DROP_COUNT:  csr_prdata = CSR_DATA_W'(cfg_ff.drop_count);
         REG_MUX_LEFT:    csr_prdata = CSR_DATA_W'(cfg_ff.mux_code[0]);
         REG_MUX_MIDDLE:  csr_prdata = CSR_DATA_W'(cfg_ff.mux_code[1]);
         REG_MUX_RIGHT:   csr_prdata = CSR_DATA_W'(cfg_ff.mux_code[2]);
         REG_MUX_BATTERY: csr_prdata = CSR_DATA_W'(cfg_ff.mux_code[3]);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drop_count  <= DROP_COUNT_RESET;
         cfg_ff.mux_code[0] <= MUX_LEFT_RESET;
         cfg_ff.mux_code[1] <= MUX_MIDDLE_RESET;
         cfg_ff.mux_code[2] <= MUX_RIGHT_RESET;
         cfg_ff.mux_code[3] <= MUX_BATTERY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/adcseq_scan.sv -----
// Scan sequencer stage: discard counter, current channel and ring write
// positions; issues the ring address and holds the transaction for the next
// stage. Depends on adcseq_pkg and adcseq_if.
`timescale 1ns / 1ps

module adcseq_scan import adcseq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   adcseq_req_if.sink        req_if,
   input  cfg_type           cfg,
   input  logic              pipe_ready,
   input  logic              stage_fire,
   output logic              accept,
   output logic [ADDR_W-1:0] rd_addr,
   output logic              stage_valid,
   output stage_type         stage
);

   logic [DROP_W-1:0]            discard_counter_ff, discard_counter_in;
   chan_type                     current_channel_ff, current_channel_in;
   logic [NUM_CHAN-1:0][POS_W-1:0] write_position_ff, write_position_in;
   logic                         stage_valid_ff, stage_valid_in;
   stage_type                    stage_ff, stage_in;

   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] pos_next;
   chan_type         next_channel;
   logic             keep;

   assign req_if.ready = pipe_ready;
   assign accept       = req_if.valid && pipe_ready;
   assign stage_valid  = stage_valid_ff;
   assign stage        = stage_ff;

   assign pos          = write_position_ff[current_channel_ff];
   assign pos_next     = (pos == POS_W'(DEPTH - 1)) ? '0 : pos + POS_W'(1);
   assign next_channel = current_channel_ff + CH_W'(1);
   // A counter at or above a lowered drop count keeps the conversion.
   assign keep         = (req_if.func == FUNC_CONVERT) &&
                         !(discard_counter_ff < cfg.drop_count);
   assign rd_addr      = ADDR_W'(current_channel_ff) * ADDR_W'(DEPTH) + ADDR_W'(pos);

   always_comb begin
      discard_counter_in = discard_counter_ff;
      current_channel_in = current_channel_ff;
      write_position_in  = write_position_ff;
      stage_in           = stage_ff;
      stage_valid_in     = stage_valid_ff;

      if (stage_fire) begin
         stage_valid_in = 1'b0;
      end

      if (accept) begin
         stage_valid_in         = 1'b1;
         stage_in.func          = req_if.func;
         stage_in.keep          = keep;
         stage_in.channel       = current_channel_ff;
         stage_in.query_channel = req_if.query_channel;
         stage_in.sample        = req_if.sample;
         stage_in.addr          = rd_addr;
         stage_in.mux_select    = cfg.mux_code[current_channel_ff];

         if (req_if.func == FUNC_CONVERT) begin
            if (keep) begin
               discard_counter_in                    = '0;
               write_position_in[current_channel_ff] = pos_next;
               current_channel_in                    = next_channel;
               stage_in.mux_select                   = cfg.mux_code[next_channel];
            end else begin
               discard_counter_in = discard_counter_ff + DROP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         discard_counter_ff <= '0;
         current_channel_ff <= CH_LEFT;
         write_position_ff  <= '0;
         stage_valid_ff     <= 1'b0;
      end else begin
         discard_counter_ff <= discard_counter_in;
         current_channel_ff <= current_channel_in;
         write_position_ff  <= write_position_in;
         stage_valid_ff     <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

// ----- rtl/adcseq_ring.sv -----
// Sample ring store: one synchronous memory holding every channel's ring,
// with per-entry valid bits so unwritten entries read as zero.
// Depends on adcseq_pkg.
`timescale 1ns / 1ps

module adcseq_ring import adcseq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   output logic [SAMPLE_W-1:0] old_sample
);

   logic [SAMPLE_W-1:0] mem [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [SAMPLE_W-1:0] rdata_ff;
   logic                rvalid_ff;

   // An entry is rewritten only after a full scan of every ring, so the read
   // issued for a transaction never meets a pending write to the same entry.
   assign old_sample = rvalid_ff ? rdata_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

endmodule

// ----- rtl/adcseq_accum.sv -----
// Accumulate stage: running ring sums, average by reciprocal multiply and
// the response output register. Depends on adcseq_pkg and adcseq_if.
`timescale 1ns / 1ps

module adcseq_accum import adcseq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                stage_valid,
   input  stage_type           stage,
   input  logic [SAMPLE_W-1:0] old_sample,
   output logic                pipe_ready,
   output logic                stage_fire,
   adcseq_rsp_if.source        rsp_if
);

   logic [NUM_CHAN-1:0][SUM_W-1:0] sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                stored_ff, stored_in;
   chan_type            stored_channel_ff, stored_channel_in;
   logic [MUX_W-1:0]    mux_select_ff, mux_select_in;
   logic [AVG_W-1:0]    average_ff, average_in;

   logic                out_free;
   chan_type            sum_sel;
   logic [SUM_W-1:0]    sum_rd;
   logic [PROD_W-1:0]   prod;
   logic [AVG_W-1:0]    avg;

   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign stage_fire = stage_valid && out_free;
   assign pipe_ready = !stage_valid || out_free;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.stored         = stored_ff;
   assign rsp_if.stored_channel = stored_channel_ff;
   assign rsp_if.mux_select     = mux_select_ff;
   assign rsp_if.average        = average_ff;

   assign sum_sel = (stage.func == FUNC_QUERY) ? stage.query_channel : stage.channel;
   assign sum_rd  = sum_ff[sum_sel];
   assign prod    = PROD_W'(sum_rd) * PROD_W'(RECIP);
   assign avg     = AVG_W'(prod >> DIV_SHIFT);

   always_comb begin
      sum_in            = sum_ff;
      rsp_valid_in      = rsp_valid_ff;
      stored_in         = stored_ff;
      stored_channel_in = stored_channel_ff;
      mux_select_in     = mux_select_ff;
      average_in        = average_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (stage_fire) begin
         rsp_valid_in      = 1'b1;
         stored_in         = stage.keep;
         stored_channel_in = stage.keep ? stage.channel : CH_LEFT;
         mux_select_in     = stage.mux_select;
         average_in        = '0;
         if (stage.func == FUNC_QUERY && stage.query_channel != CH_BATTERY) begin
            average_in = avg;
         end
         // Replace the overwritten entry in the running sum.
         if (stage.keep) begin
            sum_in[stage.channel] = sum_rd + SUM_W'(stage.sample) - SUM_W'(old_sample);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stored_ff         <= stored_in;
      stored_channel_ff <= stored_channel_in;
      mux_select_ff     <= mux_select_in;
      average_ff        <= average_in;
   end

endmodule

// ----- rtl/adc_scan_sequencer_with_averaging.sv -----
// Top level of the converter scan sequencer with per-channel ring averaging.
// Depends on adcseq_pkg, adcseq_if and the adcseq_* modules.
//
// Usage:
//   req_if carries one transaction per finished conversion (func 0, sample)
//   or per average query (func 1, query_channel). rsp_if returns exactly one
//   transaction for each request, in order: stored flag, ring written, the
//   mux code of the channel to convert next, and the queried ring average.
//   The csr_* APB-style port holds drop_count and the four mux codes at byte
//   addresses 0, 4, 8, 12 and 16; write it only while no transaction is in
//   flight. pready is tied high. A battery query returns average zero.
//   One transaction per cycle while rsp_if.ready keeps the output register
//   draining; the sample ring memory is read in the accept cycle and written
//   when the transaction leaves the middle stage, and a running sum per
//   channel turns each average into one multiply.
//   Reset clears the scan position, discard counter, ring sums and the
//   per-entry valid bits at once; no clearing pass is needed.
//   When rsp_if.ready is low the output register holds its transaction, the
//   middle stage fills, and req_if.ready then drops until the response goes.
`timescale 1ns / 1ps

module adc_scan_sequencer_with_averaging import adcseq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   adcseq_req_if.sink            req_if,
   adcseq_rsp_if.source          rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type             cfg;
   logic                accept;
   logic [ADDR_W-1:0]   rd_addr;
   logic                stage_valid;
   stage_type           stage;
   logic                pipe_ready;
   logic                stage_fire;
   logic [SAMPLE_W-1:0] old_sample;

   adcseq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   adcseq_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .cfg         (cfg),
      .pipe_ready  (pipe_ready),
      .stage_fire  (stage_fire),
      .accept      (accept),
      .rd_addr     (rd_addr),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   adcseq_ring u_ring (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (rd_addr),
      .wr_en      (stage_fire && stage.keep),
      .wr_addr    (stage.addr),
      .wr_data    (stage.sample),
      .old_sample (old_sample)
   );

   adcseq_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage       (stage),
      .old_sample  (old_sample),
      .pipe_ready  (pipe_ready),
      .stage_fire  (stage_fire),
      .rsp_if      (rsp_if)
   );

endmodule
